[hw/rtl/cmh_pkg.sv]
// shared constants and tables for the compass heading pipeline
// cordic arctangent table, gain constant and fixed turn values; no dependencies
package cmh_pkg;

  localparam int DefSampleWidth = 16;
  localparam int DefAngleWidth = 16;
  localparam int CordicSteps = 24;
  localparam int TrigWidth = 19;  // q16 sine and cosine, signed
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] ThreeQuarterTurn = 32'hC000_0000;
  localparam logic signed [32:0] CordicGainQ30 = 33'sd652032874;
  localparam logic [8:0] DegMax = 9'd359;

  localparam logic [31:0] ArctanBin [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

[hw/rtl/cmh_delay.sv]
// enabled shift line that keeps side data in step with the pipeline
// no package dependencies
module cmh_delay #(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign data_o = tap_q[Depth-1];

endmodule

[hw/rtl/cmh_sincos.sv]
// pipelined cordic rotation: binary angle in, q16 cosine and sine out
// uses cmh_pkg for the arctangent table and gain; registered per step
module cmh_sincos #(
  parameter int AngleWidth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [AngleWidth-1:0]          angle_i,
  output logic signed [cmh_pkg::TrigWidth-1:0]  cos_o,
  output logic signed [cmh_pkg::TrigWidth-1:0]  sin_o
);
  import cmh_pkg::*;

  logic [31:0]        bin;
  logic               flip;
  logic [31:0]        folded;
  logic signed [32:0] x_q [CordicSteps+1];
  logic signed [32:0] y_q [CordicSteps+1];
  logic signed [32:0] z_q [CordicSteps+1];
  logic               flip_q [CordicSteps+1];
  logic signed [32:0] xf, yf;

  assign bin    = {angle_i, {(32-AngleWidth){1'b0}}};
  assign flip   = ((bin + QuarterTurn) & HalfTurn) != 32'd0;
  assign folded = flip ? bin + HalfTurn : bin;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CordicGainQ30;
      y_q[0]    <= '0;
      z_q[0]    <= {folded[31], folded};
      flip_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [32:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = {1'b0, ArctanBin[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign xf = flip_q[CordicSteps] ? -x_q[CordicSteps] : x_q[CordicSteps];
  assign yf = flip_q[CordicSteps] ? -y_q[CordicSteps] : y_q[CordicSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= xf[32:14];
      sin_o <= yf[32:14];
    end
  end

endmodule

[hw/rtl/cmh_rotate.sv]
// tilt rotation of the field vector, four register stages
// uses cmh_pkg for the trig width; yields the vector handed to the arctangent
module cmh_rotate #(
  parameter int SampleWidth = 16,
  parameter int VecWidth = SampleWidth + 26
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic                                  tilt_i,
  input  logic signed [SampleWidth-1:0]         mag_x_i,
  input  logic signed [SampleWidth-1:0]         mag_y_i,
  input  logic signed [SampleWidth-1:0]         mag_z_i,
  input  logic signed [cmh_pkg::TrigWidth-1:0]  cos_roll_i,
  input  logic signed [cmh_pkg::TrigWidth-1:0]  sin_roll_i,
  input  logic signed [cmh_pkg::TrigWidth-1:0]  cos_pitch_i,
  input  logic signed [cmh_pkg::TrigWidth-1:0]  sin_pitch_i,
  output logic                                  tilt_o,
  output logic signed [VecWidth-1:0]            vec_x_o,
  output logic signed [VecWidth-1:0]            vec_y_o
);
  import cmh_pkg::*;

  localparam int PW = SampleWidth + TrigWidth;
  localparam int AW = PW + 1;
  localparam int QW = AW + TrigWidth;

  // stage 1
  logic signed [PW-1:0] yr_q, zc_q, zs_q, yc_q;
  logic signed [TrigWidth-1:0] cp1_q, sp1_q;
  logic signed [SampleWidth-1:0] mx1_q, my1_q;
  logic tilt1_q;
  // stage 2
  logic signed [AW-1:0] a_q, den2_q;
  logic signed [TrigWidth-1:0] cp2_q, sp2_q;
  logic signed [SampleWidth-1:0] mx2_q, my2_q;
  logic tilt2_q;
  // stage 3
  logic signed [QW-1:0] asp_q;
  logic signed [PW-1:0] mxc_q;
  logic signed [AW-1:0] den3_q;
  logic signed [SampleWidth-1:0] mx3_q, my3_q;
  logic tilt3_q;
  logic signed [QW-1:0] asp_sh;
  logic signed [VecWidth-1:0] num;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yr_q    <= PW'(mag_y_i * sin_roll_i);
      zc_q    <= PW'(mag_z_i * cos_roll_i);
      zs_q    <= PW'(mag_z_i * sin_roll_i);
      yc_q    <= PW'(mag_y_i * cos_roll_i);
      cp1_q   <= cos_pitch_i;
      sp1_q   <= sin_pitch_i;
      mx1_q   <= mag_x_i;
      my1_q   <= mag_y_i;
      tilt1_q <= tilt_i;

      a_q     <= AW'(yr_q) + AW'(zc_q);
      den2_q  <= AW'(zs_q) - AW'(yc_q);
      cp2_q   <= cp1_q;
      sp2_q   <= sp1_q;
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;
      tilt2_q <= tilt1_q;

      asp_q   <= QW'(a_q * sp2_q);
      mxc_q   <= PW'(mx2_q * cp2_q);
      den3_q  <= den2_q;
      mx3_q   <= mx2_q;
      my3_q   <= my2_q;
      tilt3_q <= tilt2_q;

      tilt_o  <= tilt3_q;
      if (tilt3_q) begin
        vec_x_o <= VecWidth'(den3_q);
        vec_y_o <= num;
      end else begin
        vec_x_o <= VecWidth'(my3_q) <<< 16;
        vec_y_o <= VecWidth'(mx3_q) <<< 16;
      end
    end
  end

  assign asp_sh = asp_q >>> 16;
  assign num    = VecWidth'(mxc_q) + VecWidth'(asp_sh);

endmodule

[hw/rtl/cmh_vector.sv]
// pipelined cordic vectoring and conversion of the turn to whole degrees
// uses cmh_pkg for the arctangent table and turn constants; registered per step
module cmh_vector #(
  parameter int VecWidth = 42
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        tilt_i,
  input  logic signed [VecWidth-1:0]  vec_x_i,
  input  logic signed [VecWidth-1:0]  vec_y_i,
  output logic [8:0]                  heading_o
);
  import cmh_pkg::*;

  logic signed [VecWidth-1:0] x_q [CordicSteps+1];
  logic signed [VecWidth-1:0] y_q [CordicSteps+1];
  logic [31:0]                z_q [CordicSteps+1];
  logic                       done_q [CordicSteps+1];
  logic                       tilt_q [CordicSteps+1];
  logic [31:0]                turn;
  logic [40:0]                scaled;
  logic [8:0]                 deg;

  // axis cases are exact and skip the iterations
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tilt_q[0] <= tilt_i;
      done_q[0] <= (vec_y_i == '0) || (vec_x_i == '0);
      if (vec_y_i == '0) begin
        z_q[0] <= vec_x_i[VecWidth-1] ? HalfTurn : 32'd0;
        x_q[0] <= vec_x_i;
        y_q[0] <= vec_y_i;
      end else if (vec_x_i == '0) begin
        z_q[0] <= vec_y_i[VecWidth-1] ? ThreeQuarterTurn : QuarterTurn;
        x_q[0] <= vec_x_i;
        y_q[0] <= vec_y_i;
      end else if (vec_x_i[VecWidth-1]) begin
        z_q[0] <= HalfTurn;
        x_q[0] <= -vec_x_i;
        y_q[0] <= -vec_y_i;
      end else begin
        z_q[0] <= 32'd0;
        x_q[0] <= vec_x_i;
        y_q[0] <= vec_y_i;
      end
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [VecWidth-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tilt_q[i+1] <= tilt_q[i];
        done_q[i+1] <= done_q[i];
        if (done_q[i]) begin
          x_q[i+1] <= x_q[i];
          y_q[i+1] <= y_q[i];
          z_q[i+1] <= z_q[i];
        end else if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ArctanBin[i];
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ArctanBin[i];
        end
      end
    end
  end

  assign turn   = tilt_q[CordicSteps] ? QuarterTurn - z_q[CordicSteps] : z_q[CordicSteps];
  assign scaled = 41'(turn) * 41'd360;
  assign deg    = scaled[40:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      heading_o <= (deg > DegMax) ? DegMax : deg;
    end
  end

endmodule

[hw/rtl/compass_heading.sv]
// tilt compensated compass heading, top level
// uses cmh_pkg, cmh_delay, cmh_sincos, cmh_rotate and cmh_vector
//
// channel   direction  handshake                     word
// in        input      in_valid_i / in_stall_o       mag_x/y/z_i, roll/pitch_angle_i
// out       output     out_valid_o / out_stall_i     heading_deg_o
// cfg       input      tilt_enable_we_i              tilt_enable_i
//
// one word per cycle unless a result waits under out_stall_i; each 24-step cordic
// chain adds an entry and an exit register, and the tilt rotation adds four stages
// the whole pipeline holds while a result waits under out_stall_i
// reset clears valid bits and tilt_enable; data registers are not reset
module compass_heading #(
  parameter int SAMPLE_WIDTH = cmh_pkg::DefSampleWidth,
  parameter int ANGLE_WIDTH = cmh_pkg::DefAngleWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tilt_enable_we_i,
  input  logic                           tilt_enable_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_z_i,
  input  logic signed [ANGLE_WIDTH-1:0]  roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0]  pitch_angle_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [8:0]                     heading_deg_o
);
  import cmh_pkg::*;

  localparam int TrigLat = CordicSteps + 2;
  localparam int Latency = 2 * CordicSteps + 8;
  localparam int VecWidth = SAMPLE_WIDTH + 26;
  localparam int SideW = 3 * SAMPLE_WIDTH + 1;

  logic tilt_enable_q;
  logic [Latency-1:0] valid_q;
  logic en;
  logic signed [TrigWidth-1:0] cr, sr, cp, sp;
  logic [SideW-1:0] side_d, side_q;
  logic tilt_r;
  logic signed [VecWidth-1:0] vx, vy;

  assign en          = !(valid_q[Latency-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = valid_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_enable_q <= 1'b0;
      valid_q       <= '0;
    end else begin
      if (tilt_enable_we_i) begin
        tilt_enable_q <= tilt_enable_i;
      end
      if (en) begin
        valid_q <= {valid_q[Latency-2:0], in_valid_i};
      end
    end
  end

  cmh_sincos #(.AngleWidth(ANGLE_WIDTH)) u_roll (
    .clk_i, .en_i(en), .angle_i(roll_angle_i), .cos_o(cr), .sin_o(sr)
  );
  cmh_sincos #(.AngleWidth(ANGLE_WIDTH)) u_pitch (
    .clk_i, .en_i(en), .angle_i(pitch_angle_i), .cos_o(cp), .sin_o(sp)
  );

  assign side_d = {tilt_enable_q, mag_x_i, mag_y_i, mag_z_i};

  cmh_delay #(.Width(SideW), .Depth(TrigLat)) u_side (
    .clk_i, .en_i(en), .data_i(side_d), .data_o(side_q)
  );

  cmh_rotate #(.SampleWidth(SAMPLE_WIDTH), .VecWidth(VecWidth)) u_rotate (
    .clk_i,
    .en_i       (en),
    .tilt_i     (side_q[SideW-1]),
    .mag_x_i    (side_q[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
    .mag_y_i    (side_q[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .mag_z_i    (side_q[SAMPLE_WIDTH-1:0]),
    .cos_roll_i (cr),
    .sin_roll_i (sr),
    .cos_pitch_i(cp),
    .sin_pitch_i(sp),
    .tilt_o     (tilt_r),
    .vec_x_o    (vx),
    .vec_y_o    (vy)
  );

  cmh_vector #(.VecWidth(VecWidth)) u_vector (
    .clk_i, .en_i(en), .tilt_i(tilt_r), .vec_x_i(vx), .vec_y_i(vy),
    .heading_o(heading_deg_o)
  );

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_deg_o <= DegMax)
    else $error("heading out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(valid_q))
    else $error("pipeline moved during stall");

endmodule
